// File: rtl/rhc_pkg.sv
package rhc_pkg;

   localparam int HslMax = 240;
   localparam int RgbMax = 255;
   localparam int Sixth  = HslMax / 6;
   localparam int Third  = HslMax / 3;
   localparam int TwoThird = (2 * HslMax) / 3;
   localparam int Half   = HslMax / 2;
   localparam int NumCells = 8;
   localparam int LightRecip = (1 << 24) / RgbMax + 1;

   localparam logic [7:0] UNDEF_HUE_RESET = 8'd160;
   localparam logic [7:0] WHITE_LIM_RESET = 8'd150;

   localparam logic [0:0] REG_UNDEF_HUE = 1'd0;
   localparam logic [0:0] REG_WHITE_LIM = 1'd1;

   localparam logic [2:0] CLASS_NONE   = 3'd0;
   localparam logic [2:0] CLASS_GREEN  = 3'd1;
   localparam logic [2:0] CLASS_ORANGE = 3'd2;
   localparam logic [2:0] CLASS_YELLOW = 3'd3;
   localparam logic [2:0] CLASS_RED    = 3'd4;
   localparam logic [2:0] CLASS_BLUE   = 3'd5;
   localparam logic [2:0] CLASS_WHITE  = 3'd6;

   // long divider job: quotient of num/den, rounded by caller
   typedef struct packed {
      logic        valid;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  mx;
      logic [7:0]  span;
      logic [7:0]  lq;
      logic [17:0] rem_r;
      logic [17:0] rem_g;
      logic [17:0] rem_b;
      logic [7:0]  q_r;
      logic [7:0]  q_g;
      logic [7:0]  q_b;
      logic [8:0]  sden;
      logic [17:0] rem_s;
      logic [7:0]  q_s;
      logic        gray;
   } work_type;

   function automatic logic [7:0] widen5(input logic [4:0] c);
      logic [7:0]  t;
      logic [15:0] p;
      begin
         // floor(c*255/31) == 8c + floor(7c/31), the latter by reciprocal multiply
         t = {c, 3'b000} - {3'b000, c};
         p = {8'd0, t} * 16'd265;
         widen5 = {c, 3'b000} + {5'd0, p[15:13]};
      end
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] c);
      logic [1:0] q;
      begin
         // floor(c*255/63) == 4c + floor(c/21)
         q = (c >= 6'd63) ? 2'd3 : (c >= 6'd42) ? 2'd2 : (c >= 6'd21) ? 2'd1 : 2'd0;
         widen6 = {c, 2'b00} + {6'd0, q};
      end
   endfunction

endpackage

// File: rtl/rhc_cell.sv
module rhc_cell (
   input  logic              clock,
   input  logic              reset,
   input  rhc_pkg::work_type w_in,
   output rhc_pkg::work_type w_out
);

   rhc_pkg::work_type w_ff, w_in_c;

   // one restoring division bit per quotient, four quotients in lockstep
   function automatic void step(input logic [17:0] rem, input logic [8:0] den,
                                input logic [7:0] q, output logic [17:0] rem_o,
                                output logic [7:0] q_o);
      logic [17:0] sh;
      begin
         sh = rem;
         if (sh[17:8] >= {1'b0, den}) begin
            sh[17:8] = sh[17:8] - {1'b0, den};
            q_o = {q[6:0], 1'b1};
         end else begin
            q_o = {q[6:0], 1'b0};
         end
         rem_o = {sh[16:0], 1'b0};
      end
   endfunction

   always_comb begin
      w_in_c = w_in;
      step(w_in.rem_r, {1'b0, w_in.span}, w_in.q_r, w_in_c.rem_r, w_in_c.q_r);
      step(w_in.rem_g, {1'b0, w_in.span}, w_in.q_g, w_in_c.rem_g, w_in_c.q_g);
      step(w_in.rem_b, {1'b0, w_in.span}, w_in.q_b, w_in_c.rem_b, w_in_c.q_b);
      step(w_in.rem_s, w_in.sden, w_in.q_s, w_in_c.rem_s, w_in_c.q_s);
      if (reset) begin
         w_in_c.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in_c;
   end

   assign w_out = w_ff;

endmodule

// File: rtl/rgb565_to_hsl_color_classifier_unit.sv
// path from start to rsp_valid: stage 0, stage 1, the division cells, output register
// throughput: one pixel per cycle, busy is always low
// a chain of eight division cells yields one quotient bit each
// reset: synchronous, clears valid flags and restores both registers
// results cannot be stalled by the receiver
module rgb565_to_hsl_color_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   output logic [7:0]  rsp_hue,
   output logic [7:0]  rsp_saturation,
   output logic [7:0]  rsp_lightness,
   output logic [2:0]  rsp_color_class,
   output logic        rsp_is_gray,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int N = rhc_pkg::NumCells;

   logic [7:0] undef_ff, limit_ff;
   logic       wr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr     = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         undef_ff <= rhc_pkg::UNDEF_HUE_RESET;
         limit_ff <= rhc_pkg::WHITE_LIM_RESET;
      end else if (wr && paddr[1:0] == 2'b00) begin
         if (paddr[2] == rhc_pkg::REG_UNDEF_HUE) begin
            undef_ff <= pwdata[7:0];
         end else begin
            limit_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == rhc_pkg::REG_UNDEF_HUE) begin
         prdata[7:0] = undef_ff;
      end else begin
         prdata[7:0] = limit_ff;
      end
   end

   // stage 0: widen and extrema
   logic        s0_valid_ff;
   logic [7:0]  s0_r_ff, s0_g_ff, s0_b_ff;
   always_ff @(posedge clock) begin
      s0_r_ff <= rhc_pkg::widen5(req_pixel[15:11]);
      s0_g_ff <= rhc_pkg::widen6(req_pixel[10:5]);
      s0_b_ff <= rhc_pkg::widen5(req_pixel[4:0]);
      s0_valid_ff <= reset ? 1'b0 : start;
   end

   logic [7:0] mx, mn;
   always_comb begin
      mx = s0_r_ff;
      mn = s0_r_ff;
      if (s0_g_ff > mx) mx = s0_g_ff;
      if (s0_b_ff > mx) mx = s0_b_ff;
      if (s0_g_ff < mn) mn = s0_g_ff;
      if (s0_b_ff < mn) mn = s0_b_ff;
   end

   // stage 1: extrema registered
   logic       s1_valid_ff;
   logic [7:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_mx_ff, s1_mn_ff;
   always_ff @(posedge clock) begin
      s1_r_ff <= s0_r_ff;
      s1_g_ff <= s0_g_ff;
      s1_b_ff <= s0_b_ff;
      s1_mx_ff <= mx;
      s1_mn_ff <= mn;
      s1_valid_ff <= reset ? 1'b0 : s0_valid_ff;
   end

   // setup of the four numerators
   rhc_pkg::work_type chain [0:N];
   rhc_pkg::work_type head;
   logic [8:0]  sum, rest;
   logic [7:0]  span;
   logic [15:0] lnum;
   logic [32:0] lprod;
   logic [16:0] num_r, num_g, num_b, num_s;
   logic        lo_half;
   always_comb begin
      sum  = {1'b0, s1_mx_ff} + {1'b0, s1_mn_ff};
      rest = 9'(2 * rhc_pkg::RgbMax) - sum;
      span = s1_mx_ff - s1_mn_ff;
      // (sum*240 + 255) / 510 == (sum*120 + 127) / 255, by reciprocal multiply
      lnum = 16'(sum * 16'(rhc_pkg::Half)) + 16'(rhc_pkg::RgbMax / 2);
      lprod = 33'(lnum) * 33'(rhc_pkg::LightRecip);
      // l <= half  <=>  sum*240 + 255 < (half+1)*510
      lo_half = (32'(sum) * 32'(rhc_pkg::HslMax) + 32'(rhc_pkg::RgbMax)) <
                32'((rhc_pkg::Half + 1) * 2 * rhc_pkg::RgbMax);
      head.valid = s1_valid_ff;
      head.r = s1_r_ff;
      head.g = s1_g_ff;
      head.b = s1_b_ff;
      head.mx = s1_mx_ff;
      head.span = span;
      head.gray = (span == 8'd0);
      head.lq = lprod[31:24];
      head.sden = lo_half ? sum : rest;
      num_s = 17'(span * 17'(rhc_pkg::HslMax)) + 17'(head.sden >> 1);
      num_r = 17'((s1_mx_ff - s1_r_ff) * 17'(rhc_pkg::Sixth)) + 17'(span >> 1);
      num_g = 17'((s1_mx_ff - s1_g_ff) * 17'(rhc_pkg::Sixth)) + 17'(span >> 1);
      num_b = 17'((s1_mx_ff - s1_b_ff) * 17'(rhc_pkg::Sixth)) + 17'(span >> 1);
      // numerators enter the cells doubled so that eight bits give num/den
      head.rem_s = {num_s, 1'b0};
      head.rem_r = {num_r, 1'b0};
      head.rem_g = {num_g, 1'b0};
      head.rem_b = {num_b, 1'b0};
      head.q_r = 8'd0;
      head.q_g = 8'd0;
      head.q_b = 8'd0;
      head.q_s = 8'd0;
   end

   assign chain[0] = head;

   for (genvar i = 0; i < N; i++) begin : g_cell
      rhc_cell u_cell (.clock(clock), .reset(reset), .w_in(chain[i]), .w_out(chain[i+1]));
   end

   // hue assembly and classification
   rhc_pkg::work_type fin;
   logic signed [10:0] h;
   logic [7:0] hue, sat;
   logic [2:0] cls;
   logic bright;
   assign fin = chain[N];
   always_comb begin
      if (fin.r == fin.mx) begin
         h = 11'(signed'({3'd0, fin.q_b})) - 11'(signed'({3'd0, fin.q_g}));
      end else if (fin.g == fin.mx) begin
         h = 11'(rhc_pkg::Third) + 11'({3'd0, fin.q_r}) - 11'({3'd0, fin.q_b});
      end else begin
         h = 11'(rhc_pkg::TwoThird) + 11'({3'd0, fin.q_g}) - 11'({3'd0, fin.q_r});
      end
      if (h < 0) h = h + 11'(rhc_pkg::HslMax);
      if (h > 11'(rhc_pkg::HslMax)) h = h - 11'(rhc_pkg::HslMax);
      hue = fin.gray ? undef_ff : h[7:0];
      sat = fin.gray ? 8'd0 : fin.q_s;
      bright = fin.lq >= limit_ff;
      if (hue > 8'd100 && hue < 8'd130) cls = bright ? rhc_pkg::CLASS_WHITE : rhc_pkg::CLASS_GREEN;
      else if (hue > 8'd10 && hue < 8'd30) cls = rhc_pkg::CLASS_ORANGE;
      else if (hue > 8'd0 && hue < 8'd10) cls = rhc_pkg::CLASS_RED;
      else if (hue > 8'd30 && hue < 8'd70) cls = rhc_pkg::CLASS_YELLOW;
      else if (hue > 8'd130 && hue < 8'd160) cls = bright ? rhc_pkg::CLASS_WHITE : rhc_pkg::CLASS_BLUE;
      else cls = rhc_pkg::CLASS_NONE;
   end

   always_ff @(posedge clock) begin
      rsp_hue <= hue;
      rsp_saturation <= sat;
      rsp_lightness <= fin.lq;
      rsp_color_class <= cls;
      rsp_is_gray <= fin.gray;
      rsp_valid <= reset ? 1'b0 : fin.valid;
   end

`ifndef NO_ASSERTIONS
   a_gray_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_gray |-> rsp_saturation == 8'd0)
      else $error("gray with saturation");
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_gray |-> rsp_hue <= 8'(rhc_pkg::HslMax))
      else $error("hue out of range");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ##9 rsp_valid)
      else $error("result lost in chain");
`endif

endmodule

// File: bench/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
      logic [2:0] color_class;
      logic       is_gray;
   } hsl_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_pixel;
   logic        rsp_valid;
   logic [7:0]  rsp_hue;
   logic [7:0]  rsp_saturation;
   logic [7:0]  rsp_lightness;
   logic [2:0]  rsp_color_class;
   logic        rsp_is_gray;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [15:0]     pixel_queue[$];
   hsl_result_type  hsl_expected[$];
   logic [7:0]      undef_hue_setting;
   logic [7:0]      white_limit_setting;
   int              error_count;
   int              idle_cycles;
   int              burst_left;
   int              gap_left;
   bit              pixels_enabled;

   rgb565_to_hsl_color_classifier_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [2:0] hue_class(int h, int l);
      logic bright;
      bright = l >= int'(white_limit_setting);
      if (h > 100 && h < 130) return bright ? rhc_pkg::CLASS_WHITE : rhc_pkg::CLASS_GREEN;
      if (h > 10 && h < 30) return rhc_pkg::CLASS_ORANGE;
      if (h > 0 && h < 10) return rhc_pkg::CLASS_RED;
      if (h > 30 && h < 70) return rhc_pkg::CLASS_YELLOW;
      if (h > 130 && h < 160) return bright ? rhc_pkg::CLASS_WHITE : rhc_pkg::CLASS_BLUE;
      return rhc_pkg::CLASS_NONE;
   endfunction

   function automatic hsl_result_type convert_pixel(logic [15:0] px);
      int r, g, b, mx, mn, l, s, h, span, sum, rest, dr, dg, db;
      hsl_result_type res;
      r = (int'(px[15:11]) * 255) / 31;
      g = (int'(px[10:5]) * 255) / 63;
      b = (int'(px[4:0]) * 255) / 31;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      l = ((mx + mn) * rhc_pkg::HslMax + rhc_pkg::RgbMax) / (2 * rhc_pkg::RgbMax);
      if (mx == mn) begin
         res.is_gray = 1'b1;
         s = 0;
         h = int'(undef_hue_setting);
      end else begin
         res.is_gray = 1'b0;
         span = mx - mn;
         sum = mx + mn;
         rest = 2 * rhc_pkg::RgbMax - sum;
         if (l <= rhc_pkg::HslMax / 2) s = (span * rhc_pkg::HslMax + sum / 2) / sum;
         else s = (span * rhc_pkg::HslMax + rest / 2) / rest;
         dr = ((mx - r) * (rhc_pkg::HslMax / 6) + span / 2) / span;
         dg = ((mx - g) * (rhc_pkg::HslMax / 6) + span / 2) / span;
         db = ((mx - b) * (rhc_pkg::HslMax / 6) + span / 2) / span;
         if (r == mx) h = db - dg;
         else if (g == mx) h = rhc_pkg::HslMax / 3 + dr - db;
         else h = (2 * rhc_pkg::HslMax) / 3 + dg - dr;
         if (h < 0) h += rhc_pkg::HslMax;
         if (h > rhc_pkg::HslMax) h -= rhc_pkg::HslMax;
      end
      res.hue = h[7:0];
      res.saturation = s[7:0];
      res.lightness = l[7:0];
      res.color_class = hue_class(h, l);
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            hsl_expected.push_back(convert_pixel(req_pixel));
            void'(pixel_queue.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pixels_enabled && pixel_queue.size() > 0) begin
            req_pixel <= pixel_queue[0];
            start <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
               if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      hsl_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (hsl_expected.size() == 0) begin
            $display("%0t: unexpected result hue %0d", $time, rsp_hue);
            error_count++;
         end else begin
            exp_res = hsl_expected.pop_front();
            if (rsp_hue !== exp_res.hue) begin
               $display("%0t: hue expected %0d actual %0d", $time, exp_res.hue, rsp_hue);
               error_count++;
            end
            if (rsp_saturation !== exp_res.saturation) begin
               $display("%0t: saturation expected %0d actual %0d", $time,
                        exp_res.saturation, rsp_saturation);
               error_count++;
            end
            if (rsp_lightness !== exp_res.lightness) begin
               $display("%0t: lightness expected %0d actual %0d", $time,
                        exp_res.lightness, rsp_lightness);
               error_count++;
            end
            if (rsp_color_class !== exp_res.color_class) begin
               $display("%0t: color_class expected %0d actual %0d", $time,
                        exp_res.color_class, rsp_color_class);
               error_count++;
            end
            if (rsp_is_gray !== exp_res.is_gray) begin
               $display("%0t: is_gray expected %0d actual %0d", $time,
                        exp_res.is_gray, rsp_is_gray);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel ||
          (pixel_queue.size() == 0 && hsl_expected.size() == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("rgb565_to_hsl_color_classifier_unit test failed");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [0:0] index, logic [7:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {24'($urandom_range(0, 24'hFF_FFFF)), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == rhc_pkg::REG_UNDEF_HUE) undef_hue_setting = value;
      else white_limit_setting = value;
   endtask

   task automatic wait_drained();
      pixels_enabled = 1'b1;
      wait (pixel_queue.size() == 0 && hsl_expected.size() == 0);
      pixels_enabled = 1'b0;
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic add_random(int count);
      logic [15:0] px;
      int r, g, b, k;
      repeat (count) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            px = $urandom_range(0, 16'hFFFF);
         end else if (k < 7) begin
            r = $urandom_range(0, 31);
            px = {r[4:0], r[4:0], 1'b0, r[4:0]};
            if (k == 6) px[5] = r[4];
         end else begin
            r = $urandom_range(0, 31);
            g = $urandom_range(0, 63);
            b = $urandom_range(0, 31);
            case ($urandom_range(0, 2))
               0: px = {r[4:0], 6'($urandom_range(0, 3)), 5'($urandom_range(0, 2))};
               1: px = {5'($urandom_range(0, 2)), g[5:0], 5'($urandom_range(0, 2))};
               default: px = {5'($urandom_range(28, 31)), g[5:0], b[4:0]};
            endcase
         end
         pixel_queue.push_back(px);
      end
   endtask

   initial begin
      logic [15:0] directed[$];
      reset = 1'b1;
      start = 1'b0;
      req_pixel = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      error_count = 0;
      pixels_enabled = 1'b0;
      undef_hue_setting = rhc_pkg::UNDEF_HUE_RESET;
      white_limit_setting = rhc_pkg::WHITE_LIM_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
                   16'h07FF, 16'hF81F, 16'h8410, 16'hFC00, 16'hFA00, 16'h8400,
                   16'h0410, 16'h801F, 16'hF810, 16'h5555, 16'hAAAA, 16'h0020,
                   16'hF801, 16'h041F, 16'h7BEF, 16'hF820};
      foreach (directed[i]) pixel_queue.push_back(directed[i]);
      wait_drained();

      // gray hue inside windows, extremes of the limit
      write_reg(rhc_pkg::REG_UNDEF_HUE, 8'd115);
      write_reg(rhc_pkg::REG_WHITE_LIM, 8'd0);
      foreach (directed[i]) pixel_queue.push_back(directed[i]);
      add_random(150);
      wait_drained();

      write_reg(rhc_pkg::REG_UNDEF_HUE, 8'd255);
      write_reg(rhc_pkg::REG_WHITE_LIM, 8'd255);
      add_random(250);
      wait_drained();

      write_reg(rhc_pkg::REG_UNDEF_HUE, 8'd0);
      write_reg(rhc_pkg::REG_WHITE_LIM, 8'd100);
      add_random(200);
      wait_drained();

      write_reg(rhc_pkg::REG_UNDEF_HUE, 8'd140);
      write_reg(rhc_pkg::REG_WHITE_LIM, 8'd200);
      add_random(200);
      wait_drained();

      write_reg(rhc_pkg::REG_UNDEF_HUE, 8'($urandom_range(0, 255)));
      write_reg(rhc_pkg::REG_WHITE_LIM, 8'($urandom_range(0, 255)));
      add_random(200);
      wait_drained();

      if (error_count == 0) begin
         $display("rgb565_to_hsl_color_classifier_unit test passed");
      end else begin
         $display("rgb565_to_hsl_color_classifier_unit test failed");
      end
      $finish;
   end

endmodule
